// ===== rtl/scn_gen_pkg.sv =====
`default_nettype none

package scn_gen_pkg;

    localparam int MAX_SCALE_DEGREES_DEF = 8;
    localparam int SEMITONES_PER_OCTAVE  = 12;
    localparam int NUM_STEPS             = 8;
    localparam int RECIP_SHIFT           = 11;

    localparam logic [6:0]  TONIC_RST       = 7'd0;
    localparam logic [3:0]  SCALE_SIZE_RST  = 4'd7;
    localparam logic [31:0] SCALE_STEPS_RST = 32'h0122_2122;

    localparam logic [1:0] CFG_TONIC       = 2'd0;
    localparam logic [1:0] CFG_SCALE_SIZE  = 2'd1;
    localparam logic [1:0] CFG_SCALE_STEPS = 2'd2;

    localparam logic [2:0] TYPE_ROOT     = 3'd0;
    localparam logic [2:0] TYPE_ROOT_OCT = 3'd1;
    localparam logic [2:0] TYPE_THIRD    = 3'd2;
    localparam logic [2:0] TYPE_FIFTH    = 3'd3;
    localparam logic [2:0] TYPE_TRIAD    = 3'd4;
    localparam logic [2:0] TYPE_SEVENTH  = 3'd5;

    // floor(2^RECIP_SHIFT / n) for n = 0..16, entry 0 unused
    localparam logic [11:0] RECIP_TAB [0:16] = '{
        12'd0,   12'd2048, 12'd1024, 12'd682, 12'd512, 12'd409,
        12'd341, 12'd292,  12'd256,  12'd227, 12'd204, 12'd186,
        12'd170, 12'd157,  12'd146,  12'd136, 12'd128
    };

    typedef enum logic [2:0] {
        KIND_ROOT,
        KIND_ROOT_OCT,
        KIND_THIRD,
        KIND_FIFTH,
        KIND_TRIAD,
        KIND_SEVENTH
    } t_chord_kind;

    typedef struct packed {
        logic signed [7:0] degree;
        t_chord_kind       kind;
        logic [1:0]        last_idx;
    } t_chord;

endpackage

`default_nettype wire

// ===== rtl/scn_gen_fifo.sv =====
`default_nettype none

module scn_gen_fifo #(
    parameter int DW = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire logic [DW-1:0] i_data,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic [DW-1:0]      o_data,
    output logic               o_empty
);

    localparam int DEPTH = 2;

    logic [DW-1:0] r_mem [DEPTH];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;
    logic [1:0]    n_count;

    assign o_full  = (r_count == 2'(DEPTH));
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/scn_gen_front.sv =====
`default_nettype none

module scn_gen_front
    import scn_gen_pkg::*;
(
    input  wire logic        i_valid,
    input  wire logic [7:0]  i_degree,
    input  wire logic [2:0]  i_chord_type,
    output logic             o_ready,
    input  wire logic        i_full,
    output logic             o_push,
    output t_chord           o_chord
);

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_chord.degree = i_degree;
        case (i_chord_type)
            TYPE_ROOT_OCT: begin
                o_chord.kind     = KIND_ROOT_OCT;
                o_chord.last_idx = 2'd2;
            end
            TYPE_THIRD: begin
                o_chord.kind     = KIND_THIRD;
                o_chord.last_idx = 2'd1;
            end
            TYPE_FIFTH: begin
                o_chord.kind     = KIND_FIFTH;
                o_chord.last_idx = 2'd1;
            end
            TYPE_TRIAD: begin
                o_chord.kind     = KIND_TRIAD;
                o_chord.last_idx = 2'd2;
            end
            TYPE_SEVENTH: begin
                o_chord.kind     = KIND_SEVENTH;
                o_chord.last_idx = 2'd3;
            end
            default: begin
                o_chord.kind     = KIND_ROOT;
                o_chord.last_idx = 2'd0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/scn_gen_back.sv =====
`default_nettype none

module scn_gen_back
    import scn_gen_pkg::*;
#(
    parameter int MAX_SCALE_DEGREES = MAX_SCALE_DEGREES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_chord      i_head,
    input  wire logic        i_head_valid,
    output logic             o_pop,
    input  wire logic [6:0]  i_tonic,
    input  wire logic [3:0]  i_scale_size,
    input  wire logic [31:0] i_scale_steps,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [11:0]      o_note,
    output logic             o_last_note
);

    localparam int NW = $clog2(MAX_SCALE_DEGREES + 1);
    localparam int RW = (MAX_SCALE_DEGREES > 1) ? $clog2(MAX_SCALE_DEGREES) : 1;

    function automatic logic [2:0] rel_of(t_chord_kind kind, logic [1:0] k);
        logic [2:0] rel;
        rel = 3'd0;
        case (kind)
            KIND_ROOT_OCT: rel = (k == 2'd2) ? 3'd1 : 3'd0;
            KIND_THIRD:    rel = (k == 2'd1) ? 3'd2 : 3'd0;
            KIND_FIFTH:    rel = (k == 2'd1) ? 3'd4 : 3'd0;
            KIND_TRIAD:    rel = {k, 1'b0};
            KIND_SEVENTH:  rel = {k, 1'b0};
            default:       rel = 3'd0;
        endcase
        return rel;
    endfunction

    logic              w_adv;
    logic              w_last;
    logic [4:0]        w_ss;
    logic [4:0]        w_n5;
    logic [NW-1:0]     w_n;
    logic [8:0]        w_d;
    logic [8:0]        w_mag;
    logic [6:0]        w_off [MAX_SCALE_DEGREES];

    logic [1:0]        r_k;

    logic              r_a_valid;
    logic              r_a_last;
    logic              r_a_sign;
    logic [7:0]        r_a_mag;
    logic [19:0]       r_a_prod;

    logic [7:0]        w_q0;
    logic [11:0]       w_qn;
    logic [8:0]        w_r0;
    logic              w_fix;
    logic [7:0]        w_q;
    logic [8:0]        w_r;
    logic              w_zero;

    logic              r_b_valid;
    logic              r_b_last;
    logic              r_b_sign;
    logic              r_b_zero;
    logic [7:0]        r_b_q;
    logic [RW-1:0]     r_b_r;

    logic [8:0]        w_qs;
    logic [12:0]       w_note;

    logic              r_out_valid;
    logic              r_out_last;
    logic [11:0]       r_out_note;

    assign w_adv  = !r_out_valid || i_ready;
    assign o_pop  = w_adv && i_head_valid && w_last;
    assign w_last = (r_k == i_head.last_idx);

    assign w_ss = {1'b0, i_scale_size};
    assign w_n5 = (w_ss > 5'(MAX_SCALE_DEGREES)) ? 5'(MAX_SCALE_DEGREES) : w_ss;
    assign w_n  = NW'(w_n5);

    assign w_d   = {i_head.degree[7], i_head.degree} + {6'd0, rel_of(i_head.kind, r_k)};
    assign w_mag = w_d[8] ? (9'd0 - w_d) : w_d;

    assign w_off[0] = 7'd0;
    for (genvar gi = 1; gi < MAX_SCALE_DEGREES; gi++) begin : g_off
        if (gi - 1 < NUM_STEPS) begin : g_step
            assign w_off[gi] = w_off[gi-1] + {3'd0, i_scale_steps[4*(gi-1) +: 4]};
        end else begin : g_none
            assign w_off[gi] = w_off[gi-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= 2'd0;
        end else if (w_adv && i_head_valid) begin
            r_k <= w_last ? 2'd0 : r_k + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_adv) begin
            r_a_valid <= i_head_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_last <= w_last;
            r_a_sign <= w_d[8];
            r_a_mag  <= w_mag[7:0];
            r_a_prod <= 20'(w_mag[7:0]) * 20'(RECIP_TAB[5'(w_n)]);
        end
    end

    assign w_q0   = r_a_prod[RECIP_SHIFT +: 8];
    assign w_qn   = 12'(w_q0) * 12'(w_n);
    assign w_r0   = 9'(r_a_mag) - w_qn[8:0];
    assign w_fix  = (w_r0 >= 9'(w_n));
    assign w_q    = w_fix ? w_q0 + 8'd1 : w_q0;
    assign w_r    = w_fix ? w_r0 - 9'(w_n) : w_r0;
    assign w_zero = (w_n == '0) || (r_a_sign && (w_r != 9'd0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_adv) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b_last <= r_a_last;
            r_b_sign <= r_a_sign;
            r_b_zero <= w_zero;
            r_b_q    <= w_q;
            r_b_r    <= w_zero ? '0 : RW'(w_r);
        end
    end

    assign w_qs   = r_b_sign ? (9'd0 - {1'b0, r_b_q}) : {1'b0, r_b_q};
    assign w_note = 13'(i_tonic) + 13'(w_off[r_b_r])
                  + ({{4{w_qs[8]}}, w_qs} * 13'(SEMITONES_PER_OCTAVE));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_last <= r_b_last;
            r_out_note <= r_b_zero ? 12'd0 : w_note[11:0];
        end
    end

    assign o_valid     = r_out_valid;
    assign o_note      = r_out_note;
    assign o_last_note = r_out_last;

endmodule

`default_nettype wire

// ===== rtl/scale_chord_note_generator_unit.sv =====
// Scale chord note generator.
// Input channel (i_valid/o_ready): one transaction carries a signed scale
// degree and a chord type. Output channel (o_valid/i_ready): one transaction
// per note, o_last_note marks the final note of the chord (1 to 4 notes).
// Config port: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0 tonic, 1 scale size, 2 packed step intervals), no readback.
// The first note of an accepted chord passes from the queue through stage A,
// stage B and the output register; later notes follow one per cycle unless
// the output stalls. The back end expands one chord at a time, up to 4 notes
// for a seventh chord. A 2-entry queue sits between input and back end, so
// new items are taken while earlier chords are still being expanded.
// While o_valid is high and i_ready is low the output register and back
// pipeline hold; the queue keeps accepting until it is full.
// Reset (synchronous, active low) empties the queue and pipeline and loads
// tonic 0, scale size 7 and the major scale intervals.
`default_nettype none

module scale_chord_note_generator_unit
    import scn_gen_pkg::*;
#(
    parameter int MAX_SCALE_DEGREES = MAX_SCALE_DEGREES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_degree,
    input  wire logic [2:0]  i_chord_type,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [11:0]      o_note,
    output logic             o_last_note,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data
);

    logic [6:0]  r_tonic;
    logic [3:0]  r_scale_size;
    logic [31:0] r_scale_steps;

    logic        w_full;
    logic        w_push;
    logic        w_pop;
    logic        w_empty;
    t_chord      w_in_chord;
    t_chord      w_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tonic       <= TONIC_RST;
            r_scale_size  <= SCALE_SIZE_RST;
            r_scale_steps <= SCALE_STEPS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TONIC:       r_tonic       <= i_cfg_data[6:0];
                CFG_SCALE_SIZE:  r_scale_size  <= i_cfg_data[3:0];
                CFG_SCALE_STEPS: r_scale_steps <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    scn_gen_front u_front (
        .i_valid      (i_valid),
        .i_degree     (i_degree),
        .i_chord_type (i_chord_type),
        .o_ready      (o_ready),
        .i_full       (w_full),
        .o_push       (w_push),
        .o_chord      (w_in_chord)
    );

    scn_gen_fifo #(
        .DW ($bits(t_chord))
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_in_chord),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_head),
        .o_empty (w_empty)
    );

    scn_gen_back #(
        .MAX_SCALE_DEGREES (MAX_SCALE_DEGREES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_head),
        .i_head_valid  (!w_empty),
        .o_pop         (w_pop),
        .i_tonic       (r_tonic),
        .i_scale_size  (r_scale_size),
        .i_scale_steps (r_scale_steps),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_note        (o_note),
        .o_last_note   (o_last_note)
    );

endmodule

`default_nettype wire
